// File: src/ihw_pkg.sv
`timescale 1ns / 1ps

package ihw_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int LINE_DEPTH   = 16;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);
    localparam int FILL_W       = $clog2(LINE_DEPTH + 1);
    localparam int STEP_W       = 5;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ALPHA = 8'h37;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] ELA_LEN  = 8'h02;

    typedef enum logic [1:0] {
        CMD_COLON,
        CMD_BYTE,
        CMD_SUM,
        CMD_NEWLINE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        run_end;
    } ser_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEG,
        ST_DATA,
        ST_EOF
    } ctrl_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
            return CHAR_ZERO + wide;
        else
            return CHAR_ALPHA + wide;
    endfunction

endpackage

// File: src/ihw_ifs.sv
`timescale 1ns / 1ps

interface ihw_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] start_address;
    logic        first_flag;
    logic        last_flag;

    modport source (output valid, data_byte, start_address, first_flag, last_flag,
                    input ready);
    modport sink   (input valid, data_byte, start_address, first_flag, last_flag,
                    output ready);
endinterface

interface ihw_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ascii_char;
    logic        run_end;

    modport source (output valid, ascii_char, run_end, input ready);
    modport sink   (input valid, ascii_char, run_end, output ready);
endinterface

interface ihw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] blank_word;

    modport source (output valid, blank_word, input ready);
    modport sink   (input valid, blank_word, output ready);
endinterface

// File: src/ihw_hex_ser.sv
`timescale 1ns / 1ps

module ihw_hex_ser
    import ihw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ser_cmd_t         cmd,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    ihw_out_if.source        text
);

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    logic [7:0] char_reg, char_next;
    logic       end_reg, end_next;
    logic [3:0] low_reg, low_next;
    logic [7:0] sum_reg, sum_next;

    logic       out_free;
    logic       take;
    logic [7:0] byte_val;

    assign out_free  = !valid_reg || text.ready;
    assign cmd_ready = out_free && !pend_reg;
    assign take      = cmd_valid && cmd_ready;
    assign byte_val  = (cmd.kind == CMD_SUM) ? (8'h00 - sum_reg) : cmd.data;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        char_next  = char_reg;
        end_next   = end_reg;
        low_next   = low_reg;
        sum_next   = sum_reg;
        if (out_free)
        begin
            valid_next = 1'b0;
            if (pend_reg)
            begin
                // second digit of the byte in flight
                char_next  = hex_char(low_reg);
                end_next   = 1'b0;
                valid_next = 1'b1;
                pend_next  = 1'b0;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                end_next   = 1'b0;
                case (cmd.kind)
                    CMD_COLON:
                    begin
                        char_next = CHAR_COLON;
                        sum_next  = 8'h00;
                    end
                    CMD_BYTE:
                    begin
                        char_next = hex_char(byte_val[7:4]);
                        low_next  = byte_val[3:0];
                        pend_next = 1'b1;
                        sum_next  = sum_reg + byte_val;
                    end
                    CMD_SUM:
                    begin
                        char_next = hex_char(byte_val[7:4]);
                        low_next  = byte_val[3:0];
                        pend_next = 1'b1;
                    end
                    CMD_NEWLINE:
                    begin
                        char_next = CHAR_LF;
                        end_next  = cmd.run_end;
                    end
                    default:
                    begin
                        valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        end_reg  <= end_next;
        low_reg  <= low_next;
        sum_reg  <= sum_next;
    end

    assign text.valid      = valid_reg;
    assign text.ascii_char = char_reg;
    assign text.run_end    = end_reg;

    a_pend_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg)
        else $error("low digit pending with empty output register");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (char_reg == CHAR_COLON || char_reg == CHAR_LF ||
                       (char_reg >= 8'h30 && char_reg <= 8'h39) ||
                       (char_reg >= 8'h41 && char_reg <= 8'h46)))
        else $error("output character outside the hex text set");

    a_end_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg) |-> (char_reg == CHAR_LF))
        else $error("run end marked on a character other than line feed");

endmodule

// File: src/ihw_ctrl.sv
`timescale 1ns / 1ps

module ihw_ctrl
    import ihw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihw_in_if.sink      image,
    ihw_cfg_if.sink     cfg,
    output ser_cmd_t    cmd,
    output logic        cmd_valid,
    input  logic        cmd_ready
);

    localparam logic [STEP_W-1:0] STEP_LEN  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_AHI  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_ALO  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_PAY  = STEP_W'(5);

    ctrl_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [31:0]        next_addr_reg, next_addr_next;
    logic [15:0]        seg_reg, seg_next;
    logic [15:0]        blank_reg, blank_next;
    logic               need_seg_reg, need_seg_next;
    logic               flush_reg, flush_next;
    logic               last_reg, last_next;
    logic               skip_reg, skip_next;
    logic [15:0]        line_addr_reg;
    logic [7:0]         line_buf_reg [LINE_DEPTH];

    // accept-side arithmetic
    logic               accept;
    logic [31:0]        acc_addr;
    logic [31:0]        acc_addr_inc;
    logic [FILL_W-1:0]  acc_fill;
    logic [FILL_W-1:0]  acc_fill_new;
    logic               acc_need_seg;
    logic               acc_flush;

    // record sequencing
    logic [FILL_W-1:0]  rec_len;
    logic [7:0]         rec_ahi;
    logic [7:0]         rec_alo;
    logic [7:0]         rec_type;
    logic               rec_final;
    logic [STEP_W-1:0]  pay_end;
    logic [STEP_W-1:0]  pay_idx;
    logic [LINE_AW-1:0] rd_idx;
    logic [7:0]         rd_byte;
    logic [7:0]         pay_byte;
    logic               is_nl;
    logic               take;
    logic               nl_done;
    logic               scan_mismatch;
    logic               scan_last;
    logic               skip_now;

    assign accept       = image.valid && image.ready;
    assign acc_addr     = image.first_flag ? image.start_address : next_addr_reg;
    assign acc_addr_inc = acc_addr + 32'd1;
    assign acc_fill     = image.first_flag ? '0 : fill_reg;
    assign acc_fill_new = acc_fill + FILL_W'(1);
    assign acc_need_seg = image.first_flag || (acc_addr[31:16] != seg_reg);
    assign acc_flush    = (acc_fill_new >= FILL_W'(RECORD_BYTES)) ||
                          (acc_addr_inc[15:0] == 16'h0000) || image.last_flag;

    assign image.ready  = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    // record fields for the record being sent
    always_comb
    begin
        rec_len   = '0;
        rec_ahi   = 8'h00;
        rec_alo   = 8'h00;
        rec_type  = REC_DATA;
        rec_final = 1'b0;
        case (state_reg)
            ST_SEG:
            begin
                rec_len   = FILL_W'(ELA_LEN);
                rec_type  = REC_ELA;
                rec_final = !(flush_reg && !skip_reg) && !last_reg;
            end
            ST_DATA:
            begin
                rec_len   = fill_reg;
                rec_ahi   = line_addr_reg[15:8];
                rec_alo   = line_addr_reg[7:0];
                rec_type  = REC_DATA;
                rec_final = !last_reg;
            end
            ST_EOF:
            begin
                rec_type  = REC_EOF;
                rec_final = 1'b1;
            end
            default:
            begin
                rec_len   = '0;
            end
        endcase
    end

    assign pay_end  = STEP_PAY + STEP_W'(rec_len);
    assign pay_idx  = step_reg - STEP_PAY;
    assign rd_idx   = (state_reg == ST_SCAN) ? step_reg[LINE_AW-1:0] : pay_idx[LINE_AW-1:0];
    assign rd_byte  = line_buf_reg[rd_idx];
    assign pay_byte = (state_reg == ST_SEG) ? (pay_idx[0] ? seg_reg[7:0] : seg_reg[15:8])
                                            : rd_byte;
    assign is_nl    = (step_reg == pay_end + STEP_W'(1));
    assign take     = cmd_valid && cmd_ready;
    assign nl_done  = take && is_nl;

    // blank scan: even bytes against the low half, odd bytes against the high half
    assign scan_mismatch = rd_byte != (step_reg[0] ? blank_reg[15:8] : blank_reg[7:0]);
    assign scan_last     = (step_reg == STEP_W'(fill_reg - FILL_W'(1)));
    assign skip_now      = skip_reg && !scan_mismatch;

    // command to the serializer
    always_comb
    begin
        cmd_valid   = (state_reg == ST_SEG) || (state_reg == ST_DATA) ||
                      (state_reg == ST_EOF);
        cmd.kind    = CMD_BYTE;
        cmd.data    = rec_type;
        cmd.run_end = 1'b0;
        if (step_reg == '0)
        begin
            cmd.kind = CMD_COLON;
        end
        else if (step_reg < STEP_PAY)
        begin
            case (step_reg)
                STEP_LEN: cmd.data = 8'(rec_len);
                STEP_AHI: cmd.data = rec_ahi;
                STEP_ALO: cmd.data = rec_alo;
                default:  cmd.data = rec_type;
            endcase
        end
        else if (step_reg < pay_end)
        begin
            cmd.data = pay_byte;
        end
        else if (step_reg == pay_end)
        begin
            cmd.kind = CMD_SUM;
        end
        else
        begin
            cmd.kind    = CMD_NEWLINE;
            cmd.run_end = rec_final;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (acc_flush && (blank_reg != 16'h0000))
                        state_next = ST_SCAN;
                    else if (acc_need_seg)
                        state_next = ST_SEG;
                    else if (acc_flush)
                        state_next = ST_DATA;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    if (need_seg_reg)
                        state_next = ST_SEG;
                    else if (!skip_now)
                        state_next = ST_DATA;
                    else if (last_reg)
                        state_next = ST_EOF;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SEG:
            begin
                if (nl_done)
                begin
                    if (flush_reg && !skip_reg)
                        state_next = ST_DATA;
                    else if (last_reg)
                        state_next = ST_EOF;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                if (nl_done)
                    state_next = last_reg ? ST_EOF : ST_IDLE;
            end
            ST_EOF:
            begin
                if (nl_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // data path state
    always_comb
    begin
        fill_next      = fill_reg;
        next_addr_next = next_addr_reg;
        seg_next       = seg_reg;
        blank_next     = blank_reg;
        need_seg_next  = need_seg_reg;
        flush_next     = flush_reg;
        last_next      = last_reg;
        skip_next      = skip_reg;

        if (cfg.valid && cfg.ready)
            blank_next = cfg.blank_word;

        if (accept)
        begin
            fill_next      = acc_fill_new;
            next_addr_next = acc_addr_inc;
            seg_next       = acc_addr[31:16];
            need_seg_next  = acc_need_seg;
            flush_next     = acc_flush;
            last_next      = image.last_flag;
            // an odd trailing byte pairs with a zero high byte
            skip_next      = (blank_reg != 16'h0000) &&
                             !(acc_fill_new[0] && (blank_reg[15:8] != 8'h00));
        end
        else if (state_reg == ST_SCAN)
        begin
            skip_next = skip_now;
        end

        // drop the record once it is sent or skipped
        if ((state_reg != ST_IDLE) && flush_reg &&
            ((state_next == ST_IDLE) || (state_next == ST_EOF)))
            fill_next = '0;

        if (state_next != state_reg)
            step_next = '0;
        else if ((state_reg == ST_SCAN) || take)
            step_next = step_reg + STEP_W'(1);
        else
            step_next = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            fill_reg      <= '0;
            next_addr_reg <= '0;
            seg_reg       <= '0;
            blank_reg     <= '0;
            need_seg_reg  <= 1'b0;
            flush_reg     <= 1'b0;
            last_reg      <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fill_reg      <= fill_next;
            next_addr_reg <= next_addr_next;
            seg_reg       <= seg_next;
            blank_reg     <= blank_next;
            need_seg_reg  <= need_seg_next;
            flush_reg     <= flush_next;
            last_reg      <= last_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_buf_reg[acc_fill[LINE_AW-1:0]] <= image.data_byte;
            if (acc_fill == '0)
                line_addr_reg <= acc_addr[15:0];
        end
    end

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_W'(LINE_DEPTH)))
        else $error("open record holds a full line while idle");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && image.last_flag) |=> (state_reg != ST_IDLE))
        else $error("last byte accepted without closing records");

    a_data_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA || state_reg == ST_SCAN) |-> (fill_reg != '0))
        else $error("data record or scan started on an empty line");

endmodule

// File: src/intel_hex_record_writer_top.sv
`timescale 1ns / 1ps

// Intel HEX record writer.
// image: memory image bytes, one per request; first_flag carries start_address and
//   opens a type 04 record, last_flag closes the open record and adds the EOF record.
// text:  one ASCII character per request (colon, uppercase hex digit, line feed);
//   run_end marks the last character caused by an input byte.
// cfg:   blank_word write; nonzero drops data records made only of that word.
// A byte is taken only when the sequencer is idle. A byte that neither closes
// a record nor needs a type 04 record leaves the sequencer idle. Otherwise the
// characters come at one per cycle while text is ready, from the hex serializer
// (each byte becomes two hex digits); the first character passes through the
// sequencer state register and the serializer output register. With blank_word
// nonzero a closing byte first scans every buffered byte against that word.
// Reset clears the address, segment, open line and blank_word. When text stalls,
// the output register holds its character and the sequencer waits; no input is
// taken until every character of the current byte has reached the serializer.
module intel_hex_record_writer_top
    import ihw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihw_in_if.sink      image,
    ihw_out_if.source   text,
    ihw_cfg_if.sink     cfg
);

    ser_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_ready;

    ihw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .image     (image),
        .cfg       (cfg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    ihw_hex_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .text      (text)
    );

endmodule
